### rtl/ims_pkg.sv
// package: shared constants, codes and arithmetic helpers for the sample smoother
`timescale 1ns / 1ps

package ims_pkg;

    // item opcodes, echoed on the result kind field
    localparam logic [1:0] OP_ACCEL = 2'd0;
    localparam logic [1:0] OP_MAG   = 2'd1;
    localparam logic [1:0] OP_MARK  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ACCEL_GAIN = 2'd0;
    localparam logic [1:0] REG_MAG_GAIN   = 2'd1;
    localparam logic [1:0] REG_LEVEL_THR  = 2'd2;

    localparam int GAIN_W = 17;
    localparam int THR_W  = 13;
    localparam int AXIS_W = 16;
    localparam int CFG_W  = 17;

    // unity gain in Q1.16 and the reset settings
    localparam logic [GAIN_W-1:0] GAIN_ONE        = 17'd65536;
    localparam logic [GAIN_W-1:0] ACCEL_GAIN_INIT = 17'd9830;
    localparam logic [GAIN_W-1:0] MAG_GAIN_INIT   = 17'd26214;
    localparam logic [THR_W-1:0]  LEVEL_THR_INIT  = 13'd900;

    // signed divide by 16, truncating toward zero
    function automatic logic signed [AXIS_W-1:0] div16(input logic signed [AXIS_W-1:0] w);
        logic [AXIS_W-1:0] biased;
        biased = w + (w[AXIS_W-1] ? 16'd15 : 16'd0);
        return {{4{biased[AXIS_W-1]}}, biased[AXIS_W-1:4]};
    endfunction

    // prev + gain*(sample-prev)/65536, quotient truncated toward zero
    function automatic logic signed [AXIS_W-1:0] ema_step(
        input logic [GAIN_W-1:0]        gain,
        input logic signed [AXIS_W-1:0] sample,
        input logic signed [AXIS_W-1:0] prev
    );
        logic signed [16:0] diff;
        logic signed [34:0] prod;
        logic signed [33:0] acc;
        logic        [17:0] quo;
        logic               round_up;
        diff     = {sample[15], sample} - {prev[15], prev};
        prod     = $signed({1'b0, gain}) * diff;
        acc      = {{2{prev[15]}}, prev, 16'h0000} + prod[33:0];
        quo      = acc[33:16];
        round_up = acc[33] && (acc[15:0] != 16'h0000);
        return quo[15:0] + {15'd0, round_up};
    endfunction

endpackage

### rtl/imu_sample_smoother.sv
// top level: motion sensor sample decoder and exponential smoother
//
//  channel | direction | handshake        | payload
//  s_      | in        | s_valid/s_ready  | opcode, six raw bytes
//  m_      | out       | m_valid/m_ready  | kind, x/y/z axes, level flag
//  cfg_    | in        | cfg_wr_en        | register index, data
//
// one item per clock unless stalled; accepted items pass input then result register
// the smoothing history updates as an item moves from the input register
// to the result register, so consecutive items see each other's history
// opcode 3 is accepted and dropped without a result
// a stalled result register holds the input register, which then drops s_ready
// reset clears valid flags, history and fresh flags and restores the gains
`timescale 1ns / 1ps

module imu_sample_smoother import ims_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_opcode,
    input  logic [7:0]               s_byte0,
    input  logic [7:0]               s_byte1,
    input  logic [7:0]               s_byte2,
    input  logic [7:0]               s_byte3,
    input  logic [7:0]               s_byte4,
    input  logic [7:0]               s_byte5,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_kind,
    output logic signed [AXIS_W-1:0] m_axis_x,
    output logic signed [AXIS_W-1:0] m_axis_y,
    output logic signed [AXIS_W-1:0] m_axis_z,
    output logic                     m_is_level,
    input  logic                     cfg_wr_en,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    // configuration registers
    logic [GAIN_W-1:0]        accel_gain_reg;
    logic [GAIN_W-1:0]        mag_gain_reg;
    logic signed [THR_W-1:0]  level_thr_reg;
    logic [GAIN_W-1:0]        gain_clamped;

    // input register
    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [7:0]  in_b0_reg, in_b1_reg, in_b2_reg, in_b3_reg, in_b4_reg, in_b5_reg;

    // history
    logic signed [AXIS_W-1:0] prev_accel_z_reg, prev_accel_z_next;
    logic signed [AXIS_W-1:0] prev_mag_x_reg, prev_mag_x_next;
    logic signed [AXIS_W-1:0] prev_mag_y_reg, prev_mag_y_next;
    logic accel_fresh_reg, accel_fresh_next;
    logic mag_fresh_reg, mag_fresh_next;

    // result register
    logic                     out_valid_reg;
    logic [1:0]               out_kind_reg, out_kind_next;
    logic signed [AXIS_W-1:0] out_x_reg, out_x_next;
    logic signed [AXIS_W-1:0] out_y_reg, out_y_next;
    logic signed [AXIS_W-1:0] out_z_reg, out_z_next;
    logic                     out_level_reg, out_level_next;

    // datapath intermediates
    logic        advance;
    logic signed [AXIS_W-1:0] word_a, word_b, word_c;
    logic signed [AXIS_W-1:0] acc_x, acc_y, acc_z;
    logic signed [AXIS_W-1:0] mag_x, mag_y, mag_z;
    logic [GAIN_W-1:0]        mul_a_gain;
    logic signed [AXIS_W-1:0] mul_a_new, mul_a_prev, mul_a_res;
    logic signed [AXIS_W-1:0] mul_b_res;
    logic signed [AXIS_W-1:0] z_final;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // gains above unity act as unity
    assign gain_clamped = cfg_data[GAIN_W-1] ? GAIN_ONE : cfg_data;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_gain_reg <= ACCEL_GAIN_INIT;
            mag_gain_reg   <= MAG_GAIN_INIT;
            level_thr_reg  <= LEVEL_THR_INIT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ACCEL_GAIN: accel_gain_reg <= gain_clamped;
                REG_MAG_GAIN:   mag_gain_reg   <= gain_clamped;
                REG_LEVEL_THR:  level_thr_reg  <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // input register, unused opcode dropped at the door
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid && (s_opcode == OP_ACCEL || s_opcode == OP_MAG
                                        || s_opcode == OP_MARK);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_op_reg <= s_opcode;
            in_b0_reg <= s_byte0;
            in_b1_reg <= s_byte1;
            in_b2_reg <= s_byte2;
            in_b3_reg <= s_byte3;
            in_b4_reg <= s_byte4;
            in_b5_reg <= s_byte5;
        end
    end

    // byte assembly: little-endian for accel, big-endian for mag
    always_comb begin
        if (in_op_reg == OP_MAG) begin
            word_a = {in_b0_reg, in_b1_reg};
            word_b = {in_b2_reg, in_b3_reg};
            word_c = {in_b4_reg, in_b5_reg};
        end else begin
            word_a = {in_b1_reg, in_b0_reg};
            word_b = {in_b3_reg, in_b2_reg};
            word_c = {in_b5_reg, in_b4_reg};
        end
    end

    // axis corrections
    assign acc_x = div16(word_a);
    assign acc_y = 16'sd0 - div16(word_b);
    assign acc_z = 16'sd0 - div16(word_c);
    assign mag_x = word_a;
    assign mag_z = 16'sd0 - word_b;
    assign mag_y = 16'sd0 - word_c;

    // smoothing unit a serves accel z or mag x, unit b serves mag y
    always_comb begin
        if (in_op_reg == OP_MAG) begin
            mul_a_gain = mag_gain_reg;
            mul_a_new  = mag_x;
            mul_a_prev = prev_mag_x_reg;
        end else begin
            mul_a_gain = accel_gain_reg;
            mul_a_new  = acc_z;
            mul_a_prev = prev_accel_z_reg;
        end
    end

    assign mul_a_res = ema_step(mul_a_gain, mul_a_new, mul_a_prev);
    assign mul_b_res = ema_step(mag_gain_reg, mag_y, prev_mag_y_reg);
    assign z_final   = accel_fresh_reg ? acc_z : mul_a_res;

    // result and history next values
    always_comb begin
        out_kind_next     = in_op_reg;
        out_x_next        = '0;
        out_y_next        = '0;
        out_z_next        = '0;
        out_level_next    = 1'b0;
        prev_accel_z_next = prev_accel_z_reg;
        prev_mag_x_next   = prev_mag_x_reg;
        prev_mag_y_next   = prev_mag_y_reg;
        accel_fresh_next  = accel_fresh_reg;
        mag_fresh_next    = mag_fresh_reg;
        unique case (in_op_reg)
            OP_ACCEL: begin
                out_x_next        = acc_x;
                out_y_next        = acc_y;
                out_z_next        = z_final;
                out_level_next    = z_final > $signed({{(AXIS_W-THR_W){level_thr_reg[THR_W-1]}},
                                                       level_thr_reg});
                prev_accel_z_next = z_final;
                accel_fresh_next  = 1'b0;
            end
            OP_MAG: begin
                out_x_next      = mag_fresh_reg ? mag_x : mul_a_res;
                out_y_next      = mag_fresh_reg ? mag_y : mul_b_res;
                out_z_next      = mag_z;
                prev_mag_x_next = out_x_next;
                prev_mag_y_next = out_y_next;
                mag_fresh_next  = 1'b0;
            end
            OP_MARK: begin
                accel_fresh_next = 1'b1;
                mag_fresh_next   = 1'b1;
            end
            default: ;
        endcase
    end

    // history registers, updated as each item moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_accel_z_reg <= '0;
            prev_mag_x_reg   <= '0;
            prev_mag_y_reg   <= '0;
            accel_fresh_reg  <= 1'b0;
            mag_fresh_reg    <= 1'b0;
        end else if (advance) begin
            prev_accel_z_reg <= prev_accel_z_next;
            prev_mag_x_reg   <= prev_mag_x_next;
            prev_mag_y_reg   <= prev_mag_y_next;
            accel_fresh_reg  <= accel_fresh_next;
            mag_fresh_reg    <= mag_fresh_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_kind_reg  <= out_kind_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_z_reg     <= out_z_next;
            out_level_reg <= out_level_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_kind     = out_kind_reg;
    assign m_axis_x   = out_x_reg;
    assign m_axis_y   = out_y_reg;
    assign m_axis_z   = out_z_reg;
    assign m_is_level = out_level_reg;

endmodule

### rtl/ims_checker.sv
// checker: port-level assertions for the sample smoother, bound to the top level
`timescale 1ns / 1ps

module ims_checker import ims_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [1:0]               m_kind,
    input logic signed [AXIS_W-1:0] m_axis_x,
    input logic signed [AXIS_W-1:0] m_axis_y,
    input logic signed [AXIS_W-1:0] m_axis_z,
    input logic                     m_is_level
);

    // no result straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_axis_x)
            && $stable(m_axis_y) && $stable(m_axis_z) && $stable(m_is_level))
        else $error("stalled result changed");

    // a mark item acknowledges with an all-zero payload
    a_mark_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == OP_MARK |-> m_axis_x == 16'sd0 && m_axis_y == 16'sd0
            && m_axis_z == 16'sd0 && !m_is_level)
        else $error("mark item with non-zero payload");

    // magnetometer items never report level
    a_mag_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == OP_MAG |-> !m_is_level)
        else $error("level flag on magnetometer item");

    // accel x is a raw word over 16, so it stays within twelve bits
    a_accel_x_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == OP_ACCEL |-> m_axis_x >= -16'sd2048 && m_axis_x <= 16'sd2047)
        else $error("accel x out of range");

endmodule

bind imu_sample_smoother ims_checker u_ims_checker (.*);

### test/tb_imu_sample_smoother.sv
// testbench: self-checking stimulus, smoothing predictor and result checker for the sample smoother
`timescale 1ns / 1ps

module tb_imu_sample_smoother import ims_pkg::*;;

    // codes the package leaves unnamed
    localparam logic [1:0] OP_NONE   = 2'd3;
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int SETTLE_CYCLES  = 8;
    localparam int STALL_LIMIT    = 1000;
    localparam int PHASES         = 9;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
        logic                     level;
    } axis_result_t;

    typedef struct {
        logic [1:0]      op;
        logic [5:0][7:0] raw;
        bit              fixed;
        axis_result_t    want;
    } stim_row_t;

    logic                     aclk;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_opcode  = OP_ACCEL;
    logic [7:0]               s_byte0   = 8'h00;
    logic [7:0]               s_byte1   = 8'h00;
    logic [7:0]               s_byte2   = 8'h00;
    logic [7:0]               s_byte3   = 8'h00;
    logic [7:0]               s_byte4   = 8'h00;
    logic [7:0]               s_byte5   = 8'h00;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    logic [1:0]               m_kind;
    logic signed [AXIS_W-1:0] m_axis_x;
    logic signed [AXIS_W-1:0] m_axis_y;
    logic signed [AXIS_W-1:0] m_axis_z;
    logic                     m_is_level;
    logic                     cfg_wr_en = 1'b0;
    logic [1:0]               cfg_index = REG_ACCEL_GAIN;
    logic [CFG_W-1:0]         cfg_data  = '0;

    // predictor copy of the registers and the smoothing history
    logic [GAIN_W-1:0] gain_accel = ACCEL_GAIN_INIT;
    logic [GAIN_W-1:0] gain_mag   = MAG_GAIN_INIT;
    int                thr_level  = int'($signed(LEVEL_THR_INIT));
    int                hist_accel_z = 0;
    int                hist_mag_x   = 0;
    int                hist_mag_y   = 0;
    bit                accel_restart = 1'b0;
    bit                mag_restart   = 1'b0;

    axis_result_t pending[$];
    stim_row_t    dir_rows[$];
    int           error_count = 0;
    int           results_seen = 0;
    int           items_by_op[4] = '{0, 0, 0, 0};
    bit           steady = 1'b0;

    imu_sample_smoother dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_byte0    (s_byte0),
        .s_byte1    (s_byte1),
        .s_byte2    (s_byte2),
        .s_byte3    (s_byte3),
        .s_byte4    (s_byte4),
        .s_byte5    (s_byte5),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_axis_x   (m_axis_x),
        .m_axis_y   (m_axis_y),
        .m_axis_z   (m_axis_z),
        .m_is_level (m_is_level),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 50 MHz clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // two raw bytes as a signed 16-bit word
    function automatic int sensor_word(input logic [7:0] hi, input logic [7:0] lo);
        logic signed [AXIS_W-1:0] w;
        w = {hi, lo};
        return int'(w);
    endfunction

    // negation that keeps the most negative word as it is
    function automatic int neg_wrap(input int v);
        int r;
        r = -v;
        if (r == 32768) r = -32768;
        return r;
    endfunction

    // k*sample + (1-k)*prev in Q1.16, exact sum, truncated toward zero
    function automatic int ema(input logic [GAIN_W-1:0] gain, input int sample, input int prev);
        longint k;
        longint acc;
        k = (gain > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain);
        acc = k * sample + (longint'(GAIN_ONE) - k) * prev;
        return int'(acc / longint'(GAIN_ONE));
    endfunction

    // decode, correct and smooth one item; returns 0 when no result follows
    function automatic bit smooth_sample(input logic [1:0] op, input logic [5:0][7:0] raw,
                                         output axis_result_t r);
        int x;
        int y;
        int z;
        bit lvl;
        x = 0;
        y = 0;
        z = 0;
        lvl = 1'b0;
        r = '0;
        case (op)
            OP_ACCEL: begin
                x = sensor_word(raw[1], raw[0]) / 16;
                y = -(sensor_word(raw[3], raw[2]) / 16);
                z = -(sensor_word(raw[5], raw[4]) / 16);
                if (accel_restart) accel_restart = 1'b0;
                else z = ema(gain_accel, z, hist_accel_z);
                hist_accel_z = z;
                lvl = (z > thr_level);
            end
            OP_MAG: begin
                x = sensor_word(raw[0], raw[1]);
                z = neg_wrap(sensor_word(raw[2], raw[3]));
                y = neg_wrap(sensor_word(raw[4], raw[5]));
                if (mag_restart) begin
                    mag_restart = 1'b0;
                end else begin
                    x = ema(gain_mag, x, hist_mag_x);
                    y = ema(gain_mag, y, hist_mag_y);
                end
                hist_mag_x = x;
                hist_mag_y = y;
            end
            OP_MARK: begin
                accel_restart = 1'b1;
                mag_restart   = 1'b1;
            end
            default: return 1'b0;
        endcase
        r.kind  = op;
        r.x     = x[AXIS_W-1:0];
        r.y     = y[AXIS_W-1:0];
        r.z     = z[AXIS_W-1:0];
        r.level = lvl;
        return 1'b1;
    endfunction

    function automatic stim_row_t make_row(
        input logic [1:0] op,
        input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
        input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5,
        input bit fixed, input int x, input int y, input int z, input bit lvl
    );
        stim_row_t row;
        row.op         = op;
        row.raw        = {b5, b4, b3, b2, b1, b0};
        row.fixed      = fixed;
        row.want.kind  = op;
        row.want.x     = x[AXIS_W-1:0];
        row.want.y     = y[AXIS_W-1:0];
        row.want.z     = z[AXIS_W-1:0];
        row.want.level = lvl;
        return row;
    endfunction

    // mostly uniform bytes, with a share of sign and range edges
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'h01;
        endcase
    endfunction

    function automatic string show(input axis_result_t r);
        return $sformatf("kind %0d x %0d y %0d z %0d level %0d",
                         r.kind, r.x, r.y, r.z, r.level);
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // one item on the input channel, with an occasional gap in front
    task automatic send_item(input logic [1:0] op, input logic [5:0][7:0] raw,
                             input bit fixed, input axis_result_t want);
        int           gap;
        axis_result_t r;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 13) gap = $urandom_range(1, 2);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_byte0  <= raw[0];
        s_byte1  <= raw[1];
        s_byte2  <= raw[2];
        s_byte3  <= raw[3];
        s_byte4  <= raw[4];
        s_byte5  <= raw[5];
        do @(posedge aclk); while (!s_ready);
        items_by_op[op]++;
        if (smooth_sample(op, raw, r)) pending.push_back(fixed ? want : r);
    endtask

    // wait for every expected result, then for anything dropped still in flight
    task automatic drain();
        do @(posedge aclk); while (pending.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        case (idx)
            REG_ACCEL_GAIN: gain_accel = data;
            REG_MAG_GAIN:   gain_mag   = data;
            REG_LEVEL_THR:  thr_level  = int'($signed(data[THR_W-1:0]));
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [GAIN_W-1:0] ga, input logic [GAIN_W-1:0] gm,
                                input int thr, input bit spare);
        logic [CFG_W-1:0] tdata;
        tdata = CFG_W'($urandom);
        tdata[THR_W-1:0] = thr[THR_W-1:0];
        write_reg(REG_ACCEL_GAIN, ga);
        write_reg(REG_MAG_GAIN, gm);
        write_reg(REG_LEVEL_THR, tdata);
        if (spare) write_reg(REG_SPARE, CFG_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 16);
    end

    // compare each result with the oldest expectation
    always @(posedge aclk) begin : check_results
        axis_result_t want;
        axis_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_kind, m_axis_x, m_axis_y, m_axis_z, m_is_level};
            if (pending.size() == 0) begin
                flag_error($sformatf("result with nothing expected: %s", show(got)));
            end else begin
                want = pending.pop_front();
                results_seen++;
                if (got !== want)
                    flag_error($sformatf("expected %s, got %s", show(want), show(got)));
            end
        end
    end

    // cycles with no item moving on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        stim_row_t       row;
        logic [5:0][7:0] raw;
        logic [1:0]      op;
        logic [GAIN_W-1:0] ga;
        logic [GAIN_W-1:0] gm;
        int              thr;
        int              roll;

        // directed rows; fixed expectations only where they are plain to see
        dir_rows.push_back(make_row(OP_ACCEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                    1, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_MARK,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                    1, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_ACCEL, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'h00, 8'h80,
                                    1, 2047, 2048, 2048, 1));
        dir_rows.push_back(make_row(OP_MAG,   8'h80, 8'h00, 8'h80, 8'h00, 8'h00, 8'h01,
                                    1, -32768, -1, -32768, 0));
        dir_rows.push_back(make_row(OP_MAG,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                    0, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_ACCEL, 8'hF1, 8'hFF, 8'h10, 8'h00, 8'hEF, 8'hFF,
                                    0, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_NONE,  8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
                                    0, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_ACCEL, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'h7F,
                                    0, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_MAG,   8'h7F, 8'hFF, 8'h7F, 8'hFF, 8'h7F, 8'hFF,
                                    0, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_MARK,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                    1, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_MARK,  8'h5A, 8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'hA5,
                                    1, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_ACCEL, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'hF0,
                                    1, 1, 0, 256, 0));
        dir_rows.push_back(make_row(OP_MAG,   8'h12, 8'h34, 8'hFF, 8'hFF, 8'h00, 8'h00,
                                    1, 4660, 0, 1, 0));
        dir_rows.push_back(make_row(OP_ACCEL, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA,
                                    0, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_MAG,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                    0, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_NONE,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                    0, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_ACCEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC4,
                                    0, 0, 0, 0, 0));

        // reset
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_item(row.op, row.raw, row.fixed, row.want);
        end

        // random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            s_valid <= 1'b0;
            drain();
            case (phase)
                0: ;
                1: program_regs('0, GAIN_ONE, -4096, 1'b0);
                2: program_regs(GAIN_ONE, '0, 4095, 1'b0);
                3: program_regs('1, GAIN_ONE + 17'd1, 0, 1'b1);
                4: program_regs(17'd1, GAIN_ONE - 17'd1, -1, 1'b0);
                default: begin
                    ga  = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom_range(0, 131071))
                                                     : GAIN_W'($urandom_range(0, 65536));
                    gm  = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom_range(0, 131071))
                                                     : GAIN_W'($urandom_range(0, 65536));
                    thr = int'($urandom_range(0, 4096)) - 2048;
                    program_regs(ga, gm, thr, 1'b0);
                end
            endcase
            steady = (phase == 2);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // hold off until the result side has caught up
                if (phase == 4 && i == ITEMS_PER_PHASE / 2) begin
                    s_valid <= 1'b0;
                    do @(posedge aclk); while (pending.size() != 0);
                end
                roll = $urandom_range(0, 99);
                if (roll < 45)      op = OP_ACCEL;
                else if (roll < 88) op = OP_MAG;
                else if (roll < 96) op = OP_MARK;
                else                op = OP_NONE;
                for (int b = 0; b < 6; b++) raw[b] = pick_byte();
                send_item(op, raw, 1'b0, '0);
            end
        end
        steady = 1'b0;

        s_valid <= 1'b0;
        drain();

        $display("covered %0d accel, %0d mag, %0d mark items and %0d dropped opcodes",
                 items_by_op[OP_ACCEL], items_by_op[OP_MAG], items_by_op[OP_MARK],
                 items_by_op[OP_NONE]);
        $display("%0d results checked over %0d register settings, %0d mismatches",
                 results_seen, PHASES, error_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### imu_sample_smoother.f
rtl/ims_pkg.sv
rtl/imu_sample_smoother.sv
rtl/ims_checker.sv
test/tb_imu_sample_smoother.sv
